### sv/stpcmd_pkg.sv
package stpcmd_pkg;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int ACCUM_W  = 31;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd10;

    // register indexes (word address)
    localparam logic REG_LINE_END = 1'b0;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NONE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_EN   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DIR  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RES  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STEP = 3'd4;

    typedef struct packed {
        logic                cmd_error;
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   action_arg;
    } stpcmd_result_t;

endpackage

### sv/stpcmd_cfg_regs.sv
module stpcmd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stpcmd_pkg::APB_AW-1:0] paddr,
    input  logic [stpcmd_pkg::APB_DW-1:0] pwdata,
    output logic [stpcmd_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output logic [stpcmd_pkg::BYTE_W-1:0] line_end_char
);
    import stpcmd_pkg::*;

    logic [BYTE_W-1:0] line_end_reg;
    logic              wr_en;
    logic              reg_hit;

    // paddr[1:0] is the byte lane; paddr[2] picks the word
    assign reg_hit = (paddr[APB_AW-1] == REG_LINE_END);
    assign wr_en   = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_end_reg <= LINE_END_RESET;
        end
        else if (wr_en)
        begin
            line_end_reg <= pwdata[BYTE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(APB_DW-BYTE_W){1'b0}}, line_end_reg};
        end
    end

    assign line_end_char = line_end_reg;

endmodule

### sv/stpcmd_parser.sv
module stpcmd_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [stpcmd_pkg::BYTE_W-1:0]  char_in,
    input  logic [stpcmd_pkg::BYTE_W-1:0]  line_end_char,
    output logic                           is_end,
    output stpcmd_pkg::stpcmd_result_t     result
);
    import stpcmd_pkg::*;

    localparam logic [2:0] PH_SKIP_EQ   = 3'd0;
    localparam logic [2:0] PH_WORD      = 3'd1;
    localparam logic [2:0] PH_SKIP_DOT1 = 3'd2;
    localparam logic [2:0] PH_PARAM     = 3'd3;
    localparam logic [2:0] PH_SKIP_DOT2 = 3'd4;
    localparam logic [2:0] PH_VALUE     = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;
    localparam logic [2:0] PH_NOVALUE   = 3'd7;

    localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

    localparam logic [15:0] PAR_EN = 16'h454E;
    localparam logic [15:0] PAR_DR = 16'h4452;
    localparam logic [15:0] PAR_RS = 16'h5253;
    localparam logic [15:0] PAR_ST = 16'h5354;

    localparam int WIDE_W = ACCUM_W + 4;
    localparam logic [ACCUM_W-1:0] VALUE_MAX = {ACCUM_W{1'b1}};

    logic [2:0]         parse_phase_reg,  parse_phase_next;
    logic [15:0]        param_chars_reg,  param_chars_next;
    logic [1:0]         param_length_reg, param_length_next;
    logic               digits_valid_reg, digits_valid_next;
    logic [ACCUM_W-1:0] value_accum_reg,  value_accum_next;

    logic               take_param;
    logic               take_value;
    logic               is_digit;
    logic [WIDE_W-1:0]  wide_value;
    logic [ACCUM_W-1:0] digit_value;
    logic               have_value;
    logic               param_ok;

    assign is_end   = (char_in == line_end_char);
    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

    // value * 10 + digit, as two shifts and adds
    assign digit_value = {{(ACCUM_W-BYTE_W){1'b0}}, char_in - CH_ZERO};
    assign wide_value  = ({4'b0, value_accum_reg} << 3) + ({4'b0, value_accum_reg} << 1)
                       + {4'b0, digit_value};

    always_comb
    begin
        parse_phase_next  = parse_phase_reg;
        param_chars_next  = param_chars_reg;
        param_length_next = param_length_reg;
        digits_valid_next = digits_valid_reg;
        value_accum_next  = value_accum_reg;
        take_param        = 1'b0;
        take_value        = 1'b0;

        if (is_end)
        begin
            parse_phase_next = PH_SKIP_EQ;
        end
        else if (char_in == CH_NUL)
        begin
            if (parse_phase_reg == PH_VALUE || parse_phase_reg == PH_DONE)
                parse_phase_next = PH_DONE;
            else
                parse_phase_next = PH_NOVALUE;
        end
        else
        begin
            unique case (parse_phase_reg)
                PH_SKIP_EQ:
                begin
                    if (char_in != CH_EQ)
                        parse_phase_next = PH_WORD;
                end
                PH_WORD:
                begin
                    if (char_in == CH_EQ)
                        parse_phase_next = PH_SKIP_DOT1;
                end
                PH_SKIP_DOT1:
                begin
                    if (char_in != CH_DOT)
                    begin
                        parse_phase_next = PH_PARAM;
                        take_param       = 1'b1;
                    end
                end
                PH_PARAM:
                begin
                    if (char_in == CH_DOT)
                        parse_phase_next = PH_SKIP_DOT2;
                    else
                        take_param = 1'b1;
                end
                PH_SKIP_DOT2:
                begin
                    if (char_in != CH_DOT)
                    begin
                        parse_phase_next = PH_VALUE;
                        take_value       = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    if (char_in == CH_DOT)
                        parse_phase_next = PH_DONE;
                    else
                        take_value = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (take_param)
        begin
            if (param_length_reg < 2'd2)
                param_chars_next = {param_chars_reg[7:0], char_in};
            if (param_length_reg != 2'd3)
                param_length_next = param_length_reg + 2'd1;
        end

        if (take_value)
        begin
            if (is_digit)
            begin
                if (wide_value > {4'b0, VALUE_MAX})
                    value_accum_next = VALUE_MAX;
                else
                    value_accum_next = wide_value[ACCUM_W-1:0];
            end
            else
            begin
                digits_valid_next = 1'b0;
            end
        end

        // line end wipes all per-line state
        if (is_end)
        begin
            param_chars_next  = '0;
            param_length_next = '0;
            digits_valid_next = 1'b1;
            value_accum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg  <= PH_SKIP_EQ;
            param_chars_reg  <= '0;
            param_length_reg <= '0;
            digits_valid_reg <= 1'b1;
            value_accum_reg  <= '0;
        end
        else if (step)
        begin
            parse_phase_reg  <= parse_phase_next;
            param_chars_reg  <= param_chars_next;
            param_length_reg <= param_length_next;
            digits_valid_reg <= digits_valid_next;
            value_accum_reg  <= value_accum_next;
        end
    end

    // result of the line as it stands before the terminating byte
    assign have_value = (parse_phase_reg == PH_VALUE) || (parse_phase_reg == PH_DONE);
    assign param_ok   = have_value && digits_valid_reg && (param_length_reg == 2'd2);

    always_comb
    begin
        result.cmd_error  = 1'b1;
        result.action     = ACT_NONE;
        result.action_arg = '0;
        if (param_ok)
        begin
            result.cmd_error = 1'b0;
            case (param_chars_reg)
                PAR_EN:
                begin
                    result.action     = ACT_EN;
                    result.action_arg = {7'b0, value_accum_reg == 31'd1};
                end
                PAR_DR:
                begin
                    result.action     = ACT_DIR;
                    result.action_arg = {7'b0, value_accum_reg == 31'd1};
                end
                PAR_RS:
                begin
                    result.action = ACT_RES;
                    if (value_accum_reg >= 31'd1 && value_accum_reg <= 31'd4)
                        result.action_arg = value_accum_reg[BYTE_W-1:0];
                end
                PAR_ST:
                begin
                    result.action     = ACT_STEP;
                    result.action_arg = value_accum_reg[BYTE_W-1:0];
                end
                default:
                begin
                    result.cmd_error = 1'b1;
                end
            endcase
        end
    end

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_end |=> parse_phase_reg == PH_SKIP_EQ && value_accum_reg == '0)
        else $error("parser did not restart after line end");

    a_no_value_early: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_phase_reg == PH_SKIP_EQ || parse_phase_reg == PH_WORD
         || parse_phase_reg == PH_SKIP_DOT1 || parse_phase_reg == PH_PARAM
         || parse_phase_reg == PH_SKIP_DOT2)
        |-> value_accum_reg == '0 && digits_valid_reg)
        else $error("value state touched before value phase");

    a_no_param_early: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_phase_reg == PH_SKIP_EQ || parse_phase_reg == PH_WORD
         || parse_phase_reg == PH_SKIP_DOT1) |-> param_length_reg == 2'd0)
        else $error("parameter bytes taken before parameter phase");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.cmd_error |-> result.action == ACT_NONE && result.action_arg == '0)
        else $error("error result carries an action");

endmodule

### sv/stpcmd_out_stage.sv
module stpcmd_out_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  stpcmd_pkg::stpcmd_result_t result_in,
    input  logic                       result_stall,
    output logic                       can_take,
    output logic                       result_valid,
    output stpcmd_pkg::stpcmd_result_t result_out
);
    import stpcmd_pkg::*;

    logic           valid_reg;
    stpcmd_result_t data_reg;

    // free slot when empty or the current result leaves this cycle
    assign can_take = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_stall |-> !load)
        else $error("held result overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_stall && !load |=> !valid_reg)
        else $error("taken result repeated");

endmodule

### sv/stepper_command_line_parser.sv
// A line-end request passes the input register, then the result register,
//   before its result is shown; a full, stalled result register can hold it.
// Throughput: one byte request per cycle; only a line end that meets a stalled,
//   full result register holds the input register, and so the byte input.
// Reset (rst_n, async, active low): parser back to its start phase, line end
//   byte 10, input and result registers empty.
module stepper_command_line_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stpcmd_pkg::APB_AW-1:0] paddr,
    input  logic [stpcmd_pkg::APB_DW-1:0] pwdata,
    output logic [stpcmd_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [stpcmd_pkg::BYTE_W-1:0] rx_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          cmd_error,
    output logic [stpcmd_pkg::ACTION_W-1:0] action,
    output logic [stpcmd_pkg::BYTE_W-1:0] action_arg
);
    import stpcmd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] line_end_char;
    logic              is_end;
    logic              can_take;
    logic              advance;
    logic              accept;
    stpcmd_result_t    line_result;
    stpcmd_result_t    out_result;

    stpcmd_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .line_end_char (line_end_char)
    );

    assign advance    = in_valid_reg && (!is_end || can_take);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    stpcmd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .char_in       (in_byte_reg),
        .line_end_char (line_end_char),
        .is_end        (is_end),
        .result        (line_result)
    );

    stpcmd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && is_end),
        .result_in    (line_result),
        .result_stall (result_stall),
        .can_take     (can_take),
        .result_valid (result_valid),
        .result_out   (out_result)
    );

    assign cmd_error  = out_result.cmd_error;
    assign action     = out_result.action;
    assign action_arg = out_result.action_arg;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg && is_end && result_valid)
        else $error("byte input stalled without a blocked result");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> result_valid)
        else $error("line end gave no result");

    a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held byte lost");

endmodule

### tb/tb_stepper_command_line_parser.sv
module tb_stepper_command_line_parser;
    import stpcmd_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;

    localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    localparam logic [15:0] PARAM_EN = "EN";
    localparam logic [15:0] PARAM_DR = "DR";
    localparam logic [15:0] PARAM_RS = "RS";
    localparam logic [15:0] PARAM_ST = "ST";

    localparam logic [ACCUM_W-1:0] ACCUM_MAX = 31'h7FFF_FFFF;

    localparam logic [APB_AW-1:0] ADDR_LINE_END = {REG_LINE_END, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = {~REG_LINE_END, 2'b00};

    typedef enum logic [2:0] {
        SEEK_WORD, IN_WORD, SEEK_PARAM, IN_PARAM,
        SEEK_VALUE, IN_VALUE, VALUE_DONE, TEXT_ENDED
    } parse_phase_e;

    typedef enum int {CUT_SHORT, PUT_NUL, PUT_RANDOM, PUT_LETTER} damage_e;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                byte_valid = 1'b0;
    logic                byte_stall;
    logic [BYTE_W-1:0]   rx_byte = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                cmd_error;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   action_arg;

    stepper_command_line_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd_error    (cmd_error),
        .action       (action),
        .action_arg   (action_arg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser copy kept by the testbench
    logic [BYTE_W-1:0]  eol_byte = LINE_END_RESET;
    parse_phase_e       phase = SEEK_WORD;
    logic [15:0]        par_bytes = '0;
    logic [1:0]         par_len = '0;
    logic               all_digits = 1'b1;
    logic [ACCUM_W-1:0] accum = '0;

    stpcmd_result_t     line_results[$];
    logic [BYTE_W-1:0]  line_buf[$];

    int  errors = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  holding = 1'b0;
    event hold_start;

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function automatic void clear_parser();
        phase      = SEEK_WORD;
        par_bytes  = '0;
        par_len    = '0;
        all_digits = 1'b1;
        accum      = '0;
    endfunction

    function automatic void add_param_char(input logic [BYTE_W-1:0] c);
        if (par_len < 2'd2)
            par_bytes = {par_bytes[7:0], c};
        if (par_len < 2'd3)
            par_len++;
    endfunction

    function automatic void add_value_char(input logic [BYTE_W-1:0] c);
        logic [35:0] wide;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            wide  = {5'd0, accum} * 36'd10 + 36'(c - CH_ZERO);
            accum = (wide > 36'(ACCUM_MAX)) ? ACCUM_MAX : wide[ACCUM_W-1:0];
        end
        else
            all_digits = 1'b0;
    endfunction

    // returns 1 when the byte closes a line and res holds the command outcome
    function automatic bit parse_command_byte(input logic [BYTE_W-1:0] c,
                                              output stpcmd_result_t res);
        res = '{cmd_error: 1'b1, action: ACT_NONE, action_arg: 8'd0};
        if (c == eol_byte)
        begin
            if ((phase == IN_VALUE || phase == VALUE_DONE) && all_digits && par_len == 2'd2)
            begin
                res.cmd_error = 1'b0;
                case (par_bytes)
                    PARAM_EN:
                    begin
                        res.action     = ACT_EN;
                        res.action_arg = (accum == 31'd1) ? 8'd1 : 8'd0;
                    end
                    PARAM_DR:
                    begin
                        res.action     = ACT_DIR;
                        res.action_arg = (accum == 31'd1) ? 8'd1 : 8'd0;
                    end
                    PARAM_RS:
                    begin
                        res.action     = ACT_RES;
                        res.action_arg = (accum >= 31'd1 && accum <= 31'd4) ? accum[7:0] : 8'd0;
                    end
                    PARAM_ST:
                    begin
                        res.action     = ACT_STEP;
                        res.action_arg = accum[7:0];
                    end
                    default:
                        res.cmd_error = 1'b1;
                endcase
            end
            clear_parser();
            return 1'b1;
        end
        // NUL ends the usable text; keep whether a value was reached
        if (c == CH_NUL)
        begin
            phase = (phase == IN_VALUE || phase == VALUE_DONE) ? VALUE_DONE : TEXT_ENDED;
            return 1'b0;
        end
        case (phase)
            SEEK_WORD:  if (c != CH_EQ) phase = IN_WORD;
            IN_WORD:    if (c == CH_EQ) phase = SEEK_PARAM;
            SEEK_PARAM:
                if (c != CH_DOT)
                begin
                    phase = IN_PARAM;
                    add_param_char(c);
                end
            IN_PARAM:
                if (c == CH_DOT)
                    phase = SEEK_VALUE;
                else
                    add_param_char(c);
            SEEK_VALUE:
                if (c != CH_DOT)
                begin
                    phase = IN_VALUE;
                    add_value_char(c);
                end
            IN_VALUE:
                if (c == CH_DOT)
                    phase = VALUE_DONE;
                else
                    add_value_char(c);
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ---------------- request side ----------------

    task automatic send_byte(input logic [BYTE_W-1:0] c);
        stpcmd_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= c;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        if (parse_command_byte(c, res))
            line_results.push_back(res);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(eol_byte);
    endtask

    // pause requests until every pending result has come back
    task automatic drain_results();
        byte_valid <= 1'b0;
        while (line_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [APB_AW-1:0] addr,
                             input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [BYTE_W-1:0] val);
        logic [APB_DW-1:0] rd;
        drain_results();
        apb_cycle(1'b1, addr, {{(APB_DW-BYTE_W){1'b0}}, val}, rd);
        if (addr[APB_AW-1:2] == REG_LINE_END)
        begin
            eol_byte = val;
            apb_cycle(1'b0, addr, '0, rd);
            if (rd[BYTE_W-1:0] !== eol_byte)
                note_error($sformatf("line end readback: expected %0h, got %0h",
                                     eol_byte, rd[BYTE_W-1:0]));
        end
    endtask

    // well-formed command with random content, appended to line_buf
    function automatic void build_command();
        logic [15:0] names[4] = '{PARAM_EN, PARAM_DR, PARAM_RS, PARAM_ST};
        logic [15:0] pick;
        int          sel;
        repeat ($urandom_range(2)) line_buf.push_back(CH_EQ);
        repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range(122, 97)));
        line_buf.push_back(CH_EQ);
        repeat ($urandom_range(2)) line_buf.push_back(CH_DOT);
        if ($urandom_range(9) != 0)
        begin
            pick = names[$urandom_range(3)];
            line_buf.push_back(pick[15:8]);
            line_buf.push_back(pick[7:0]);
        end
        else
            repeat ($urandom_range(3, 1)) line_buf.push_back(8'($urandom_range(90, 65)));
        line_buf.push_back(CH_DOT);
        repeat ($urandom_range(1)) line_buf.push_back(CH_DOT);
        sel = $urandom_range(9);
        if (sel < 4)
            line_buf.push_back(8'(CH_ZERO + $urandom_range(5)));
        else if (sel < 8)
            repeat ($urandom_range(3, 1)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
        else
            repeat ($urandom_range(12, 8)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(3) == 0)
        begin
            line_buf.push_back(CH_DOT);
            repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(122, 48)));
        end
    endfunction

    task automatic send_random_line();
        int kind;
        int pos;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            build_command();
            if (kind >= 70)
            begin
                pos = $urandom_range(line_buf.size() - 1);
                case (damage_e'($urandom_range(3)))
                    CUT_SHORT:  while (line_buf.size() > pos) void'(line_buf.pop_back());
                    PUT_NUL:    line_buf[pos] = CH_NUL;
                    PUT_RANDOM: line_buf[pos] = 8'($urandom_range(255));
                    default:    line_buf.insert(pos, 8'h5A);
                endcase
            end
        end
        else
            repeat ($urandom_range(10)) line_buf.push_back(8'($urandom_range(255)));
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        send_byte(eol_byte);
    endtask

    // ---------------- result side ----------------

    always @(negedge clk)
        result_stall <= holding || ($urandom_range(99) < stall_pct);

    always @(hold_start)
    begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    always @(posedge clk)
    begin
        stpcmd_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (line_results.size() == 0)
                note_error($sformatf("unexpected result: err=%0d act=%0d arg=%0d",
                                     cmd_error, action, action_arg));
            else
            begin
                want = line_results.pop_front();
                if (want.cmd_error !== cmd_error || want.action !== action ||
                    want.action_arg !== action_arg)
                    note_error($sformatf(
                        "mismatch: expected err=%0d act=%0d arg=%0d, got err=%0d act=%0d arg=%0d",
                        want.cmd_error, want.action, want.action_arg,
                        cmd_error, action, action_arg));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("stepper_command_line_parser regression: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_basic_commands();
        send_line("x=EN.1");
        send_line("x=EN.0");
        send_line("x=DR.1");
        send_line("x=DR.7");
        send_line("x=RS.4");
        send_line("x=RS.9");
        send_line("x=ST.200");
        send_line("==x=..RS..3.tail.9");
        send_byte(8'hFF);
        send_line("=ST.5");
        drain_results();
    endtask

    task automatic test_special_cases();
        send_idle_pct = 28;
        stall_pct     = 28;
        send_line("");
        send_line("x=EN");
        send_line("x=ENX.1");
        send_line("x=EN.1a");
        send_line("x=QQ.1");
        send_line("x=ST.99999999999");
        // NUL before any value, then NUL after a value
        send_text("x=E");
        send_byte(CH_NUL);
        send_line("N.1");
        send_text("x=ST.12");
        send_byte(CH_NUL);
        send_line("zz");
        drain_results();
    endtask

    task automatic test_line_end_setting();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(ADDR_LINE_END, 8'h00);
        send_line("x=EN.1");
        send_line("x=ST.77");
        write_register(ADDR_LINE_END, 8'hFF);
        send_text("x=RS.2");
        send_byte(CH_NUL);
        send_line("junk");
        send_line("x=DR.1");
        // unmapped index: 'A' must stay an ordinary byte
        write_register(ADDR_UNMAPPED, 8'h41);
        send_line("xA=EN.1");
        write_register(ADDR_LINE_END, LINE_END_RESET);
    endtask

    task automatic test_random_traffic(input logic [BYTE_W-1:0] eol, input int n_bytes,
                                       input int idle_pct, input int rx_stall_pct);
        int start;
        write_register(ADDR_LINE_END, eol);
        send_idle_pct = idle_pct;
        stall_pct     = rx_stall_pct;
        start         = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_line();
        drain_results();
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_backpressure();
        write_register(ADDR_LINE_END, LINE_END_RESET);
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_start;
        repeat (12) send_line($sformatf("x=ST.%0d", $urandom_range(999)));
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_commands();
        test_special_cases();
        test_line_end_setting();
        test_random_traffic(LINE_END_RESET, 285, 0, 0);
        test_random_traffic(8'hFF, 285, 66, 0);
        test_random_traffic(8'($urandom_range(254, 128)), 285, 0, 66);
        test_random_traffic(8'h00, 285, 28, 28);
        test_backpressure();
        drain_results();
        if (errors == 0 && line_results.size() == 0)
            $display("stepper_command_line_parser regression: pass");
        else
            $display("stepper_command_line_parser regression: fail");
        $finish;
    end

endmodule
